/* hw/rtl/mcb_pkg.sv */
// shared types, codes and reset values of the multi-click button detector
// no dependencies; imported by every module of the block

package mcb_pkg;

    localparam int NUM_BUTTONS_DEF = 24;
    localparam int LINE_W          = 24;
    localparam int TIME_W          = 32;
    localparam int DELAY_W         = 16;
    localparam int COUNT_W         = 8;
    localparam int INDEX_W         = 5;
    localparam int CMD_W           = 2;
    localparam int REG_IDX_W       = 2;
    localparam int FRONT_DEPTH     = 2;
    localparam int RESULT_DEPTH    = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLED   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY     = 2'd2;

    localparam logic [LINE_W-1:0]  ENABLED_RST   = 24'hFF_FFFF;
    localparam logic [DELAY_W-1:0] THRESHOLD_RST = 16'd400;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 16'd500;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_LOCK,
        OP_UNLOCK
    } op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FLUSH
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [LINE_W-1:0] levels;
        logic [LINE_W-1:0] select;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] button_index;
        logic [COUNT_W-1:0] press_count;
        logic               last;
    } result_t;

endpackage

/* hw/rtl/mcb_front.sv */
// front end: takes input words, decodes the command and queues known ones
// depends on mcb_pkg

module mcb_front #(
    parameter int DEPTH = mcb_pkg::FRONT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mcb_pkg::CMD_W-1:0]   command,
    input  logic [mcb_pkg::TIME_W-1:0]  now,
    input  logic [mcb_pkg::LINE_W-1:0]  pin_levels,
    input  logic [mcb_pkg::LINE_W-1:0]  select_mask,
    output logic                        item_valid,
    output mcb_pkg::item_t              item,
    input  logic                        item_take
);

    import mcb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic  known;
    op_t   op_dec;
    logic  store;
    logic  take;

    always_comb
    begin
        known  = 1'b1;
        op_dec = OP_TICK;
        case (command)
            CMD_TICK:   op_dec = OP_TICK;
            CMD_LOCK:   op_dec = OP_LOCK;
            CMD_UNLOCK: op_dec = OP_UNLOCK;
            default:    known  = 1'b0;
        endcase
    end

    assign full       = (cnt_reg == CNT_FULL);
    assign item_valid = (cnt_reg != '0);
    assign item       = slot_reg[rd_ptr_reg];
    // unknown commands are accepted and dropped here
    assign store      = push && !full && known;
    assign take       = item_take && item_valid;

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op_dec, now: now, levels: pin_levels,
                                      select: select_mask};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (store)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (take)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (store && !take)
                cnt_reg <= cnt_reg + 1'b1;
            else if (take && !store)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/mcb_back.sv */
// back end: per-line state, config registers and the scan sequencer
// depends on mcb_pkg; feeds the result queue

module mcb_back #(
    parameter int NUM_BUTTONS = mcb_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mcb_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [mcb_pkg::LINE_W-1:0]     wr_data,
    input  logic                           item_valid,
    input  mcb_pkg::item_t                 item,
    output logic                           item_take,
    input  logic                           res_full,
    output logic                           res_push,
    output mcb_pkg::result_t               res_word
);

    import mcb_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUTTONS - 1);

    logic [LINE_W-1:0]  enabled_reg;
    logic [DELAY_W-1:0] threshold_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [LINE_W-1:0]  lock_reg;

    logic               released_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]  deadline_reg [NUM_BUTTONS];
    logic [COUNT_W-1:0] count_reg    [NUM_BUTTONS];

    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LINE_W-1:0]  levels_reg;
    logic               pend_valid_reg;
    result_t            pend_reg;

    logic [NUM_BUTTONS-1:0] en_line;
    logic [NUM_BUTTONS-1:0] lock_line;
    logic [NUM_BUTTONS-1:0] level_line;

    // lines above the field width have no bits and stay idle
    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_line
        if (g < LINE_W)
        begin : g_real
            assign en_line[g]    = enabled_reg[g];
            assign lock_line[g]  = lock_reg[g];
            assign level_line[g] = levels_reg[g];
        end
        else
        begin : g_none
            assign en_line[g]    = 1'b0;
            assign lock_line[g]  = 1'b0;
            assign level_line[g] = 1'b1;
        end
    end

    // one line per cycle while the result queue is not full
    logic               cur_rel;
    logic [TIME_W-1:0]  cur_dl;
    logic [COUNT_W-1:0] cur_cnt;
    logic               new_rel;
    logic [TIME_W-1:0]  new_dl;
    logic [COUNT_W-1:0] new_cnt;
    logic [COUNT_W-1:0] emit_cnt;
    logic               emit;
    logic               line_en;
    logic               step;

    always_comb
    begin
        cur_rel  = released_reg[idx_reg];
        cur_dl   = deadline_reg[idx_reg];
        cur_cnt  = count_reg[idx_reg];
        new_rel  = cur_rel;
        new_dl   = cur_dl;
        new_cnt  = cur_cnt;
        emit_cnt = cur_cnt;
        emit     = 1'b0;
        line_en  = en_line[idx_reg];
        if (lock_line[idx_reg])
        begin
            new_rel = 1'b1;
            new_dl  = '0;
            new_cnt = '0;
        end
        else
        begin
            if (level_line[idx_reg] != cur_rel)
            begin
                new_rel = level_line[idx_reg];
                if (!level_line[idx_reg])
                    new_dl = now_reg + {{(TIME_W-DELAY_W){1'b0}}, threshold_reg};
                else if (cur_dl != '0)
                begin
                    new_dl  = now_reg + {{(TIME_W-DELAY_W){1'b0}}, delay_reg};
                    new_cnt = (cur_cnt != COUNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
                end
            end
            if ((new_dl != '0) && (now_reg > new_dl))
            begin
                emit     = 1'b1;
                emit_cnt = new_cnt;
                new_dl   = '0;
                new_cnt  = '0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
                if (item_valid && item.op == OP_TICK)
                    state_next = SEQ_SCAN;
            SEQ_SCAN:
                if (!res_full && idx_reg == IDX_LAST)
                    state_next = SEQ_FLUSH;
            SEQ_FLUSH:
                if (!pend_valid_reg || !res_full)
                    state_next = SEQ_IDLE;
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        item_take = 1'b0;
        step      = 1'b0;
        res_push  = 1'b0;
        res_word  = pend_reg;
        case (state_reg)
            SEQ_IDLE:
                item_take = item_valid;
            SEQ_SCAN:
            begin
                step = !res_full;
                // an older pending result is not the last once another follows
                res_push = !res_full && line_en && emit && pend_valid_reg;
                res_word.last = 1'b0;
            end
            SEQ_FLUSH:
            begin
                res_push = pend_valid_reg && !res_full;
                res_word.last = 1'b1;
            end
            default:
                item_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            now_reg    <= item.now;
            levels_reg <= item.levels;
        end
        if (step && line_en && emit)
        begin
            pend_reg.button_index <= INDEX_W'(idx_reg);
            pend_reg.press_count  <= emit_cnt;
            pend_reg.last         <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= ENABLED_RST;
            threshold_reg  <= THRESHOLD_RST;
            delay_reg      <= DELAY_RST;
            lock_reg       <= '0;
            state_reg      <= SEQ_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_BUTTONS; j++)
            begin
                released_reg[j] <= 1'b1;
                deadline_reg[j] <= '0;
                count_reg[j]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_ENABLED:   enabled_reg   <= wr_data;
                    REG_THRESHOLD: threshold_reg <= wr_data[DELAY_W-1:0];
                    REG_DELAY:     delay_reg     <= wr_data[DELAY_W-1:0];
                    default:       ;
                endcase
            end
            if (item_take)
            begin
                case (item.op)
                    OP_LOCK:   lock_reg <= lock_reg | item.select;
                    OP_UNLOCK: lock_reg <= lock_reg & ~item.select;
                    default:   idx_reg  <= '0;
                endcase
            end
            if (step)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                if (line_en)
                begin
                    released_reg[idx_reg] <= new_rel;
                    deadline_reg[idx_reg] <= new_dl;
                    count_reg[idx_reg]    <= new_cnt;
                    if (emit)
                        pend_valid_reg <= 1'b1;
                end
            end
            if (state_reg == SEQ_FLUSH && res_push)
                pend_valid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/mcb_result_queue.sv */
// small result queue between the scan sequencer and the output ports
// depends on mcb_pkg

module mcb_result_queue #(
    parameter int DEPTH = mcb_pkg::RESULT_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_push,
    input  mcb_pkg::result_t in_word,
    output logic             in_full,
    input  logic             pop,
    output logic             empty,
    output mcb_pkg::result_t out_word
);

    import mcb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             wr;
    logic             rd;

    assign in_full  = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign out_word = slot_reg[rd_ptr_reg];
    assign wr       = in_push && !in_full;
    assign rd       = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/multi_click_button_detector_unit.sv */
// Multi-click and long-press detector for active-low button lines. A tick word
// (command 0) leaves the input queue, then the scan visits every line, one line
// per cycle while the result queue has room, through a single shared update
// path, and a flush step follows; lock and unlock words are applied as they
// leave the input queue and unknown commands are dropped at the input. A full
// result queue pauses the scan. Results for one tick come out in ascending
// line order and the final one of the tick has last set. Up to two input
// words queue ahead of the scan, so push is taken while a tick runs.
// top level: front end, back end and result queue; depends on mcb_pkg

module multi_click_button_detector_unit #(
    parameter int NUM_BUTTONS = mcb_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mcb_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [mcb_pkg::LINE_W-1:0]     wr_data,
    input  logic                           push,
    output logic                           full,
    input  logic [mcb_pkg::CMD_W-1:0]      command,
    input  logic [mcb_pkg::TIME_W-1:0]     now,
    input  logic [mcb_pkg::LINE_W-1:0]     pin_levels,
    input  logic [mcb_pkg::LINE_W-1:0]     select_mask,
    output logic                           empty,
    input  logic                           pop,
    output logic [mcb_pkg::INDEX_W-1:0]    button_index,
    output logic [mcb_pkg::COUNT_W-1:0]    press_count,
    output logic                           last
);

    import mcb_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    res_full;
    logic    res_push;
    result_t res_word;
    result_t out_word;

    mcb_front #(
        .DEPTH(FRONT_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .now         (now),
        .pin_levels  (pin_levels),
        .select_mask (select_mask),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    mcb_back #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_word   (res_word)
    );

    mcb_result_queue #(
        .DEPTH(RESULT_DEPTH)
    ) u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (res_push),
        .in_word  (res_word),
        .in_full  (res_full),
        .pop      (pop),
        .empty    (empty),
        .out_word (out_word)
    );

    assign button_index = out_word.button_index;
    assign press_count  = out_word.press_count;
    assign last         = out_word.last;

endmodule

/* hw/rtl/mcb_checker.sv */
// port-level checks for the multi-click button detector, bound to the top level
// depends on mcb_pkg

module mcb_checker #(
    parameter int NUM_BUTTONS = mcb_pkg::NUM_BUTTONS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [mcb_pkg::INDEX_W-1:0]    button_index,
    input logic [mcb_pkg::COUNT_W-1:0]    press_count,
    input logic                           last
);

    import mcb_pkg::*;

    localparam int LIVE_LINES = (NUM_BUTTONS < LINE_W) ? NUM_BUTTONS : LINE_W;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(LIVE_LINES);

    // both queues come out of reset drained
    a_reset_drained: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not drained during reset");

    // only lines that exist and have a level bit can end a sequence
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (button_index < INDEX_LIMIT))
        else $error("result for a line that cannot exist");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(button_index) &&
                              $stable(press_count) && $stable(last)))
        else $error("waiting result changed before pop");

endmodule

bind multi_click_button_detector_unit mcb_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_mcb_checker (.*);
